>>> hdl/salsa20_keystream_generator_macros.svh
// Assertion macros for the keystream generator checker
`ifndef SALSA20_KEYSTREAM_GENERATOR_MACROS_SVH
`define SALSA20_KEYSTREAM_GENERATOR_MACROS_SVH
// Check that a condition implies a property on the next edge
`define S20_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
// Check that a condition implies a property on the same edge
`define S20_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`endif

>>> hdl/s20_pkg.sv
// ----------------------------------------------------------------------------
// s20_pkg
// Shared types and constants for the Salsa20 keystream generator.
// ----------------------------------------------------------------------------
`default_nettype none
package s20_pkg;
  localparam int DoubleRoundsDefault = 10;
  localparam logic [31:0] Sig0 = 32'h61707865;
  localparam logic [31:0] Sig1 = 32'h3320646e;
  localparam logic [31:0] Sig2 = 32'h79622d32;
  localparam logic [31:0] Sig3 = 32'h6b206574;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  typedef enum logic [2:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE = 3'd4
  } reg_idx_t;

  localparam logic ACT_GEN  = 1'b0;
  localparam logic ACT_SEEK = 1'b1;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t quarter(input state_t s, input int a, input int b,
                                     input int c, input int d);
    state_t t;
    t = s;
    t[b] = t[b] ^ rotl(t[a] + t[d], 7);
    t[c] = t[c] ^ rotl(t[b] + t[a], 9);
    t[d] = t[d] ^ rotl(t[c] + t[b], 13);
    t[a] = t[a] ^ rotl(t[d] + t[c], 18);
    quarter = t;
  endfunction

  // First half of a Salsa20 double round: the four column quarters
  function automatic state_t column_round(input state_t s);
    state_t t;
    t = quarter(s, 0, 4, 8, 12);
    t = quarter(t, 5, 9, 13, 1);
    t = quarter(t, 10, 14, 2, 6);
    t = quarter(t, 15, 3, 7, 11);
    column_round = t;
  endfunction

  // Second half of a Salsa20 double round: the four row quarters
  function automatic state_t row_round(input state_t s);
    state_t t;
    t = quarter(s, 0, 1, 2, 3);
    t = quarter(t, 5, 6, 7, 4);
    t = quarter(t, 10, 11, 8, 9);
    t = quarter(t, 15, 12, 13, 14);
    row_round = t;
  endfunction
endpackage
`default_nettype wire

>>> hdl/s20_cell.sv
// ----------------------------------------------------------------------------
// s20_cell
// One cell of the round chain: a column round or a row round on the state
// handed in by the previous cell, registered, with the input state carried
// alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module s20_cell #(
  parameter bit ROW_HALF = 1'b0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            vld_in,
  input  wire s20_pkg::state_t x_in,
  input  wire s20_pkg::state_t init_in,
  output logic                 vld_out,
  output s20_pkg::state_t      x_out,
  output s20_pkg::state_t      init_out
);
  import s20_pkg::*;

  logic   vld_r;
  state_t x_r, init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r    <= ROW_HALF ? row_round(x_in) : column_round(x_in);
      init_r <= init_in;
    end
  end

  assign vld_out  = vld_r;
  assign x_out    = x_r;
  assign init_out = init_r;
endmodule
`default_nettype wire

>>> hdl/s20_emit.sv
// ----------------------------------------------------------------------------
// s20_emit
// Final add and serializer: holds one finished block and sends its eight
// words in order.
// ----------------------------------------------------------------------------
`default_nettype none
module s20_emit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            blk_vld,
  input  wire s20_pkg::state_t x_in,
  input  wire s20_pkg::state_t init_in,
  output logic                 blk_take,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [63:0]          out_keystream_word,
  output logic [2:0]           out_word_index,
  output logic                 out_last_word
);
  import s20_pkg::*;

  state_t     blk_r;
  logic       full_r;
  logic [2:0] idx_r;
  logic       xfer;

  assign xfer     = full_r && !out_stall;
  // Take a new block when empty or while the last word leaves
  assign blk_take = blk_vld && (!full_r || (xfer && idx_r == 3'd7));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      if (blk_take) begin
        full_r <= 1'b1;
        idx_r  <= 3'd0;
      end else if (xfer) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          full_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_take) begin
      for (int i = 0; i < 16; i++) begin
        blk_r[i] <= x_in[i] + init_in[i];
      end
    end
  end

  assign out_valid          = full_r;
  assign out_keystream_word = {blk_r[{idx_r, 1'b1}], blk_r[{idx_r, 1'b0}]};
  assign out_word_index     = idx_r;
  assign out_last_word      = (idx_r == 3'd7);
endmodule
`default_nettype wire

>>> hdl/salsa20_keystream_generator.sv
// A generate item passes the half-round cells, then the emitter's block register.
// The eight-word output serializer sends one block at a time and holds on out_stall;
// the chain of 2*DOUBLE_ROUNDS half-round cells holds that many blocks in flight.
// Seek items load the block counter and produce no output.
// Reset (rst_n low, synchronous): clears key, nonce, counter, valid bits and word index.
// ----------------------------------------------------------------------------
// salsa20_keystream_generator
// Salsa20 keystream generator built as a chain of half-round cells.
// ----------------------------------------------------------------------------
`default_nettype none
module salsa20_keystream_generator #(
  parameter int DOUBLE_ROUNDS = s20_pkg::DoubleRoundsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [63:0] in_position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_keystream_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import s20_pkg::*;

  // Column and row rounds sit in cells of their own
  localparam int Stages = 2 * DOUBLE_ROUNDS;

  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_r, ctr_r;

  // Cell chain links; index 0 is the chain head
  logic   vld [Stages+1];
  state_t xs  [Stages+1];
  state_t ins [Stages+1];

  logic adv, blk_take, in_xfer, gen;
  state_t init_st;

  // Advance the whole chain unless its tail holds a block the emitter refuses
  assign adv      = !vld[Stages] || blk_take;
  assign in_stall = !adv;
  assign in_xfer  = in_valid && !in_stall;
  assign gen      = in_xfer && (in_action == ACT_GEN);

  always_comb begin
    init_st[0]  = Sig0;
    init_st[1]  = key0_r[31:0];
    init_st[2]  = key0_r[63:32];
    init_st[3]  = key1_r[31:0];
    init_st[4]  = key1_r[63:32];
    init_st[5]  = Sig1;
    init_st[6]  = nonce_r[31:0];
    init_st[7]  = nonce_r[63:32];
    init_st[8]  = ctr_r[31:0];
    init_st[9]  = ctr_r[63:32];
    init_st[10] = Sig2;
    init_st[11] = key2_r[31:0];
    init_st[12] = key2_r[63:32];
    init_st[13] = key3_r[31:0];
    init_st[14] = key3_r[63:32];
    init_st[15] = Sig3;
  end

  assign vld[0] = gen;
  assign xs[0]  = init_st;
  assign ins[0] = init_st;

  // Config and counter; the user must write config only while idle (unchecked)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r  <= '0;
      key1_r  <= '0;
      key2_r  <= '0;
      key3_r  <= '0;
      nonce_r <= '0;
      ctr_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY0:  key0_r <= cfg_data;
          REG_KEY1:  key1_r <= cfg_data;
          REG_KEY2:  key2_r <= cfg_data;
          REG_KEY3:  key3_r <= cfg_data;
          REG_NONCE: begin
            nonce_r <= cfg_data;
            ctr_r   <= '0;
          end
          default: ;
        endcase
      end
      if (in_xfer) begin
        if (in_action == ACT_SEEK) begin
          ctr_r <= in_position;
        end else begin
          ctr_r <= ctr_r + 64'd1;
        end
      end
    end
  end

  // Even cells run the column round, odd cells the row round
  for (genvar g = 0; g < Stages; g++) begin : g_cell
    s20_cell #(
      .ROW_HALF ((g % 2) == 1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .vld_in   (vld[g]),
      .x_in     (xs[g]),
      .init_in  (ins[g]),
      .vld_out  (vld[g+1]),
      .x_out    (xs[g+1]),
      .init_out (ins[g+1])
    );
  end

  s20_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .blk_vld            (vld[Stages]),
    .x_in               (xs[Stages]),
    .init_in            (ins[Stages]),
    .blk_take           (blk_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_keystream_word (out_keystream_word),
    .out_word_index     (out_word_index),
    .out_last_word      (out_last_word)
  );
endmodule
`default_nettype wire

>>> hdl/s20_checker.sv
// ----------------------------------------------------------------------------
// s20_checker
// Port-level checks on the keystream generator's result sequence.
// ----------------------------------------------------------------------------
`default_nettype none
`include "salsa20_keystream_generator_macros.svh"
module s20_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_keystream_word,
  input wire logic [2:0]  out_word_index,
  input wire logic        out_last_word
);
  `S20_ASSERT_NOW(a_last_idx, clk, rst_n, out_valid, out_last_word == (out_word_index == 3'd7))
  `S20_ASSERT_NEXT(a_idx_step, clk, rst_n, out_valid && !out_stall && !out_last_word,
    out_valid && out_word_index == $past(out_word_index) + 3'd1)
  `S20_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_keystream_word) && $stable(out_word_index))
  `S20_ASSERT_NEXT(a_first, clk, rst_n, out_valid && !out_stall && out_last_word,
    !out_valid || out_word_index == 3'd0)
endmodule

bind salsa20_keystream_generator s20_checker u_s20_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_keystream_word (out_keystream_word),
  .out_word_index     (out_word_index),
  .out_last_word      (out_last_word)
);
`default_nettype wire
